// File: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers for the bezier particle animator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PARTICLES  = 256;
    localparam int PART_BITS  = 8;
    localparam int COORD_BITS = 16;
    localparam int TIME_BITS  = 18;
    localparam int CP_ADDR_BITS = PART_BITS + 2;

    localparam logic [TIME_BITS-1:0] TIME_MAX = 18'h3FFFF;
    localparam logic [TIME_BITS-1:0] TIME_ONE = 18'h10000;
    localparam logic [16:0]          T_ONE    = 17'h10000;

    // item opcodes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } bpa_op_t;

    // animation modes
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_DECAY = 2'd2,
        MODE_OFF   = 2'd3
    } bpa_mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TIME,
        ST_W1,
        ST_W2,
        ST_MAC0,
        ST_MAC1,
        ST_WB
    } bpa_state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         particle;
        logic [1:0]         point_slot;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [15:0]        speed;
        logic [15:0]        init_size;
        logic [15:0]        tick_delta;
    } bpa_in_t;

    typedef struct packed {
        logic [7:0]         particle_out;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        size_out;
        logic               finished;
        logic               faded;
    } bpa_out_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } bpa_point_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] ptime;
        logic [15:0]          speed;
        logic [15:0]          full_size;
        bpa_point_t           pos;
        logic [15:0]          size;
        logic                 done;
        logic                 faded;
    } bpa_pstate_t;

    // stage controls from the sequencer to the curve datapath
    typedef struct packed {
        logic ld_p0;
        logic ld_p1;
        logic ld_p2;
        logic ld_p3;
        logic en_sq;
        logic en_w;
        logic en_mac0;
        logic en_mac1;
        logic decay;
    } bpa_curve_ctl_t;

    localparam bpa_pstate_t PSTATE_RESET = '{
        ptime: '0, speed: '0, full_size: '0, pos: '0, size: '0,
        done: 1'b1, faded: 1'b0
    };

    // clamp to the signed coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [19:0] v
    );
        logic signed [19:0] hi;
        logic signed [19:0] lo;
        begin
            hi = 20'((1 << (COORD_BITS - 1)) - 1);
            lo = -hi - 20'sd1;
            if (v > hi)
                return hi[COORD_BITS-1:0];
            else if (v < lo)
                return lo[COORD_BITS-1:0];
            else
                return v[COORD_BITS-1:0];
        end
    endfunction

endpackage

// File: rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bpa_curve.sv
// ----------------------------------------------------------------------------
// bpa_curve
// Cubic Bernstein evaluation: powers, weights, then two multiply-add steps.
// ----------------------------------------------------------------------------
module bpa_curve (
    input  logic                   clk,
    input  bpa_pkg::bpa_curve_ctl_t ctl,
    input  bpa_pkg::bpa_point_t    cp_rdata,
    input  logic [16:0]            teval,
    input  logic [15:0]            full_size,
    output bpa_pkg::bpa_point_t    pos,
    output logic [15:0]            size
);

    localparam logic signed [51:0] HALF = 52'sh80000000;

    bpa_pkg::bpa_point_t pt_reg [4];
    logic [16:0]        u_reg;
    logic [16:0]        t_reg;
    logic [33:0]        u2_reg;
    logic [33:0]        ut_reg;
    logic [33:0]        t2_reg;
    logic [15:0]        size_reg;
    logic [32:0]        w_reg [4];
    logic signed [51:0] acc_x_reg;
    logic signed [51:0] acc_y_reg;
    logic signed [51:0] acc_z_reg;

    logic [16:0] u_cur;
    logic [16:0] fac;
    logic [32:0] size_prod;
    logic [50:0] pw0;
    logic [50:0] pw1;
    logic [50:0] pw2;
    logic [50:0] pw3;
    logic [52:0] pw1x3;
    logic [52:0] pw2x3;
    logic signed [51:0] rnd_x;
    logic signed [51:0] rnd_y;
    logic signed [51:0] rnd_z;

    function automatic logic signed [49:0] mulw(
        input logic [32:0]        w,
        input logic signed [15:0] c
    );
        logic signed [33:0] ws;
        begin
            ws = signed'({1'b0, w});
            return ws * c;
        end
    endfunction

    // powers of u and t, and the size scale
    assign u_cur     = bpa_pkg::T_ONE - teval;
    assign fac       = ctl.decay ? u_cur : teval;
    assign size_prod = full_size * fac;

    always_ff @(posedge clk)
    begin
        if (ctl.en_sq)
        begin
            u_reg    <= u_cur;
            t_reg    <= teval;
            u2_reg   <= u_cur * u_cur;
            ut_reg   <= u_cur * teval;
            t2_reg   <= teval * teval;
            size_reg <= size_prod[31:16];
        end
    end

    // bernstein weights in Q1.32
    assign pw0   = u2_reg * u_reg;
    assign pw1   = u2_reg * t_reg;
    assign pw2   = ut_reg * t_reg;
    assign pw3   = t2_reg * t_reg;
    assign pw1x3 = {2'b00, pw1} + {1'b0, pw1, 1'b0};
    assign pw2x3 = {2'b00, pw2} + {1'b0, pw2, 1'b0};

    always_ff @(posedge clk)
    begin
        if (ctl.en_w)
        begin
            w_reg[0] <= pw0[48:16];
            w_reg[1] <= pw1x3[48:16];
            w_reg[2] <= pw2x3[48:16];
            w_reg[3] <= pw3[48:16];
        end
    end

    // control point capture as reads return
    always_ff @(posedge clk)
    begin
        if (ctl.ld_p0)
            pt_reg[0] <= cp_rdata;
        if (ctl.ld_p1)
            pt_reg[1] <= cp_rdata;
        if (ctl.ld_p2)
            pt_reg[2] <= cp_rdata;
        if (ctl.ld_p3)
            pt_reg[3] <= cp_rdata;
    end

    // weighted sum, first two points then last two
    always_ff @(posedge clk)
    begin
        if (ctl.en_mac0)
        begin
            acc_x_reg <= 52'(mulw(w_reg[0], pt_reg[0].x)) + 52'(mulw(w_reg[1], pt_reg[1].x));
            acc_y_reg <= 52'(mulw(w_reg[0], pt_reg[0].y)) + 52'(mulw(w_reg[1], pt_reg[1].y));
            acc_z_reg <= 52'(mulw(w_reg[0], pt_reg[0].z)) + 52'(mulw(w_reg[1], pt_reg[1].z));
        end
        else if (ctl.en_mac1)
        begin
            acc_x_reg <= acc_x_reg + 52'(mulw(w_reg[2], pt_reg[2].x))
                         + 52'(mulw(w_reg[3], pt_reg[3].x));
            acc_y_reg <= acc_y_reg + 52'(mulw(w_reg[2], pt_reg[2].y))
                         + 52'(mulw(w_reg[3], pt_reg[3].y));
            acc_z_reg <= acc_z_reg + 52'(mulw(w_reg[2], pt_reg[2].z))
                         + 52'(mulw(w_reg[3], pt_reg[3].z));
        end
    end

    // round half up, floor shift, clamp
    assign rnd_x = acc_x_reg + HALF;
    assign rnd_y = acc_y_reg + HALF;
    assign rnd_z = acc_z_reg + HALF;

    assign pos.x = bpa_pkg::sat_coord(rnd_x[51:32]);
    assign pos.y = bpa_pkg::sat_coord(rnd_y[51:32]);
    assign pos.z = bpa_pkg::sat_coord(rnd_z[51:32]);
    assign size  = size_reg;

endmodule

// File: rtl/bezier_particle_animator.sv
// ----------------------------------------------------------------------------
// bezier_particle_animator
// Particle table walking cubic Bezier paths, one item at a time.
// ----------------------------------------------------------------------------
// A load keeps the sequencer in ST_IDLE, a start passes ST_START and a tick
// ST_TIME through ST_WB before the next acceptance. Control points sit in a
// 1024-entry memory with one read port, so a tick fetches its four points in
// turn while the weight chain (powers, weights, two multiply-add steps) runs
// beside them; particle state sits in a second 256-entry memory read once and
// written once per start or active tick. Entries never started read as the
// reset state through a per-particle valid bit, so there is no clearing pass.
// A result waits in an output register; new items are taken while it waits,
// and only a tick finishing into a still-full register holds.
module bezier_particle_animator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  bpa_pkg::bpa_in_t  req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output bpa_pkg::bpa_out_t rsp_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);

    bpa_pkg::bpa_state_t  state_reg;
    bpa_pkg::bpa_state_t  state_next;
    bpa_pkg::bpa_in_t     item_reg;
    logic [1:0]           mode_reg;
    logic [bpa_pkg::PARTICLES-1:0] valid_reg;
    logic                 vld_rd_reg;
    bpa_pkg::bpa_pstate_t old_reg;
    logic [bpa_pkg::TIME_BITS-1:0] t_reg;
    logic [16:0]          teval_reg;
    logic                 fin_reg;
    logic                 active_reg;
    logic                 out_valid_reg;
    bpa_pkg::bpa_out_t    out_reg;

    logic                 accept;
    logic                 can_out;
    logic                 cp_we;
    logic [bpa_pkg::CP_ADDR_BITS-1:0] cp_waddr;
    logic [bpa_pkg::CP_ADDR_BITS-1:0] cp_raddr;
    bpa_pkg::bpa_point_t  cp_wdata;
    bpa_pkg::bpa_point_t  cp_rdata;
    logic                 ps_we;
    logic [bpa_pkg::PART_BITS-1:0] ps_raddr;
    bpa_pkg::bpa_pstate_t ps_wdata;
    logic [$bits(bpa_pkg::bpa_pstate_t)-1:0] ps_rraw;
    bpa_pkg::bpa_pstate_t cur_old;
    bpa_pkg::bpa_pstate_t start_state;
    bpa_pkg::bpa_pstate_t new_state;
    bpa_pkg::bpa_curve_ctl_t curve_ctl;
    bpa_pkg::bpa_point_t  curve_pos;
    logic [15:0]          curve_size;
    logic [31:0]          step_prod;
    logic [24:0]          time_sum;
    logic [bpa_pkg::TIME_BITS-1:0] t_new;
    logic                 fin_new;
    logic signed [19:0]   neg_z;

    assign accept    = req_valid && !req_stall;
    assign can_out   = !out_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;

    // memories
    assign cp_we    = accept && (req_item.opcode == bpa_pkg::OP_LOAD);
    assign cp_waddr = {req_item.particle, req_item.point_slot};
    assign cp_wdata = '{x: req_item.coord_x, y: req_item.coord_y, z: req_item.coord_z};

    bpa_ram #(
        .WIDTH ($bits(bpa_pkg::bpa_point_t)),
        .DEPTH (bpa_pkg::PARTICLES * 4)
    ) u_cp_ram (
        .clk   (clk),
        .we    (cp_we),
        .waddr (cp_waddr),
        .wdata (cp_wdata),
        .raddr (cp_raddr),
        .rdata (cp_rdata)
    );

    bpa_ram #(
        .WIDTH ($bits(bpa_pkg::bpa_pstate_t)),
        .DEPTH (bpa_pkg::PARTICLES)
    ) u_ps_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (item_reg.particle),
        .wdata (ps_wdata),
        .raddr (ps_raddr),
        .rdata (ps_rraw)
    );

    // never-started particles read as reset state
    assign cur_old = vld_rd_reg ? bpa_pkg::bpa_pstate_t'(ps_rraw) : bpa_pkg::PSTATE_RESET;

    // time step and end-of-flight check
    assign step_prod = item_reg.tick_delta * cur_old.speed;
    assign time_sum  = 25'(cur_old.ptime) + 25'(step_prod[31:8]);
    assign t_new     = (time_sum > 25'(bpa_pkg::TIME_MAX)) ? bpa_pkg::TIME_MAX
                                                           : time_sum[bpa_pkg::TIME_BITS-1:0];
    assign fin_new   = t_new > bpa_pkg::TIME_ONE;

    // curve datapath
    bpa_curve u_curve (
        .clk       (clk),
        .ctl       (curve_ctl),
        .cp_rdata  (cp_rdata),
        .teval     (teval_reg),
        .full_size (old_reg.full_size),
        .pos       (curve_pos),
        .size      (curve_size)
    );

    // start state: armed at point 0, size kept
    always_comb
    begin
        start_state           = cur_old;
        start_state.ptime     = '0;
        start_state.speed     = item_reg.speed;
        start_state.full_size = item_reg.init_size;
        start_state.pos       = cp_rdata;
        start_state.done      = 1'b0;
        start_state.faded     = 1'b0;
    end

    // tick write-back state
    assign neg_z = -20'(old_reg.pos.z);

    always_comb
    begin
        new_state = old_reg;
        if (active_reg)
        begin
            new_state.ptime = t_reg;
            if (fin_reg)
            begin
                new_state.done = 1'b1;
                if (mode_reg == bpa_pkg::MODE_BUILD)
                begin
                    new_state.pos  = curve_pos;
                    new_state.size = old_reg.full_size;
                end
                else
                begin
                    new_state.pos.z = bpa_pkg::sat_coord(neg_z);
                    new_state.faded = 1'b1;
                end
            end
            else
            begin
                new_state.pos  = curve_pos;
                new_state.size = curve_size;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_item.opcode == bpa_pkg::OP_START)
                        state_next = bpa_pkg::ST_START;
                    else if (req_item.opcode == bpa_pkg::OP_TICK)
                        state_next = bpa_pkg::ST_TIME;
                end
            end
            bpa_pkg::ST_START: state_next = bpa_pkg::ST_IDLE;
            bpa_pkg::ST_TIME:  state_next = bpa_pkg::ST_W1;
            bpa_pkg::ST_W1:    state_next = bpa_pkg::ST_W2;
            bpa_pkg::ST_W2:    state_next = bpa_pkg::ST_MAC0;
            bpa_pkg::ST_MAC0:  state_next = bpa_pkg::ST_MAC1;
            bpa_pkg::ST_MAC1:  state_next = bpa_pkg::ST_WB;
            bpa_pkg::ST_WB:
            begin
                if (can_out)
                    state_next = bpa_pkg::ST_IDLE;
            end
            default:           state_next = bpa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_stall = 1'b1;
        ps_we     = 1'b0;
        ps_wdata  = new_state;
        ps_raddr  = item_reg.particle;
        cp_raddr  = {item_reg.particle, 2'd0};
        curve_ctl = '0;
        curve_ctl.decay = (mode_reg == bpa_pkg::MODE_DECAY);
        unique case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                ps_raddr  = req_item.particle;
                cp_raddr  = {req_item.particle, 2'd0};
            end
            bpa_pkg::ST_START:
            begin
                ps_we    = 1'b1;
                ps_wdata = start_state;
            end
            bpa_pkg::ST_TIME:
            begin
                cp_raddr        = {item_reg.particle, 2'd1};
                curve_ctl.ld_p0 = 1'b1;
            end
            bpa_pkg::ST_W1:
            begin
                cp_raddr        = {item_reg.particle, 2'd2};
                curve_ctl.ld_p1 = 1'b1;
                curve_ctl.en_sq = 1'b1;
            end
            bpa_pkg::ST_W2:
            begin
                cp_raddr        = {item_reg.particle, 2'd3};
                curve_ctl.ld_p2 = 1'b1;
                curve_ctl.en_w  = 1'b1;
            end
            bpa_pkg::ST_MAC0:
            begin
                curve_ctl.ld_p3   = 1'b1;
                curve_ctl.en_mac0 = 1'b1;
            end
            bpa_pkg::ST_MAC1:
            begin
                curve_ctl.en_mac1 = 1'b1;
            end
            bpa_pkg::ST_WB:
            begin
                ps_we = active_reg && can_out;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::ST_IDLE;
            mode_reg      <= bpa_pkg::MODE_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            if (ps_we)
                valid_reg[item_reg.particle] <= 1'b1;
            if (state_reg == bpa_pkg::ST_WB && can_out)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // item and tick working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= req_item;
            vld_rd_reg <= valid_reg[req_item.particle];
        end
        if (state_reg == bpa_pkg::ST_TIME)
        begin
            old_reg    <= cur_old;
            t_reg      <= t_new;
            fin_reg    <= fin_new;
            teval_reg  <= fin_new ? bpa_pkg::T_ONE : t_new[16:0];
            active_reg <= ((mode_reg == bpa_pkg::MODE_BUILD) ||
                           (mode_reg == bpa_pkg::MODE_DECAY)) && !cur_old.done;
        end
        if (state_reg == bpa_pkg::ST_WB && can_out)
        begin
            out_reg.particle_out <= item_reg.particle;
            out_reg.pos_x        <= new_state.pos.x;
            out_reg.pos_y        <= new_state.pos.y;
            out_reg.pos_z        <= new_state.pos.z;
            out_reg.size_out     <= new_state.size;
            out_reg.finished     <= new_state.done;
            out_reg.faded        <= new_state.faded;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

// File: rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the bezier particle animator, bound to the top.
// ----------------------------------------------------------------------------
module bpa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input bpa_pkg::bpa_in_t  req_item,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input bpa_pkg::bpa_out_t rsp_item
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("result changed while stalled");

    // a tick keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_item.opcode == bpa_pkg::OP_TICK) |=> req_stall)
    else $error("item accepted during a tick");

    // a load is done in its accept cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_item.opcode == bpa_pkg::OP_LOAD) |=> !req_stall)
    else $error("load item held the block");

    // a faded particle has always finished
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.faded |-> rsp_item.finished)
    else $error("faded particle not finished");

endmodule

bind bezier_particle_animator bpa_checker u_bpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);
